// ===== hw/rtl/ght_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Opcodes, command kinds, status codes, the command queue entry, the result
// record and the sequencer states used by the front, queue and back.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS_DEFAULT    = 16;
  localparam int GEN_BITS_DEFAULT = 16;

  // Fixed field widths of the transactions
  localparam int OWNER_W   = 8;
  localparam int HSLOT_W   = 8;
  localparam int HGEN_W    = 16;
  localparam int HELD_W    = 16;
  localparam int ID_W      = 32;
  localparam int KEY_W     = 32;
  localparam int OIDX_W    = 4;
  localparam int OGEN_W    = 16;
  localparam int EVICT_W   = 5;

  // Command queue, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_COLLECT = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_MISSING,
    CMD_STALE,
    CMD_ACQUIRE,
    CMD_RESOLVE,
    CMD_COLLECT
  } cmd_kind_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_STALE     = 3'd1,
    STATUS_COLLISION = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_MISSING   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PLACE,
    BK_RESOLVE,
    BK_COLLECT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [ID_W-1:0]     object_id;
    logic [KEY_W-1:0]    content_key;
    logic [HSLOT_W-1:0]  slot;
    logic [HGEN_W-1:0]   gen;
    logic [HELD_W-1:0]   held;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [OIDX_W-1:0]   slot_index;
    logic [OGEN_W-1:0]   generation;
    logic [KEY_W-1:0]    content;
    logic [EVICT_W-1:0]  evicted;
  } result_t;

  function automatic result_t mk_result(status_e st, logic [OIDX_W-1:0] idx,
                                        logic [OGEN_W-1:0] gen,
                                        logic [KEY_W-1:0] content,
                                        logic [EVICT_W-1:0] evicted);
    result_t r;
    r.status     = st;
    r.slot_index = idx;
    r.generation = gen;
    r.content    = content;
    r.evicted    = evicted;
    return r;
  endfunction

endpackage

// ===== hw/rtl/ght_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_front: request intake and classification
// Decodes each accepted request into a command kind, settling the checks
// that need no table state (missing descriptor, owner, zero generation,
// slot out of range) before it enters the command queue.
// ----------------------------------------------------------------------------
module ght_front #(
  parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic                         has_descriptor_i,
  input  logic [ght_pkg::ID_W-1:0]     object_id_i,
  input  logic [ght_pkg::KEY_W-1:0]    content_key_i,
  input  logic [ght_pkg::OWNER_W-1:0]  handle_owner_i,
  input  logic [ght_pkg::HSLOT_W-1:0]  handle_slot_i,
  input  logic [ght_pkg::HGEN_W-1:0]   handle_generation_i,
  input  logic [ght_pkg::HELD_W-1:0]   held_mask_i,
  input  logic [ght_pkg::OWNER_W-1:0]  owner_id_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output ght_pkg::cmd_t                cmd_o
);

  logic stale;

  // Hold the requester off while the queue is full
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Handle checks that need no slot state
  assign stale = (handle_owner_i != owner_id_i) ||
                 (handle_generation_i == '0) ||
                 ({1'b0, handle_slot_i} >= (ght_pkg::HSLOT_W + 1)'(SLOTS));

  // Classify the transaction
  always_comb begin
    cmd_o.object_id   = object_id_i;
    cmd_o.content_key = content_key_i;
    cmd_o.slot        = handle_slot_i;
    cmd_o.gen         = handle_generation_i;
    cmd_o.held        = held_mask_i;
    unique case (ght_pkg::op_e'(opcode_i))
      ght_pkg::OP_ACQUIRE: begin
        cmd_o.kind = has_descriptor_i ? ght_pkg::CMD_ACQUIRE : ght_pkg::CMD_MISSING;
      end
      ght_pkg::OP_RESOLVE: begin
        cmd_o.kind = stale ? ght_pkg::CMD_STALE : ght_pkg::CMD_RESOLVE;
      end
      ght_pkg::OP_COLLECT: begin
        cmd_o.kind = ght_pkg::CMD_COLLECT;
      end
      default: begin
        cmd_o.kind = ght_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ght_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_queue: command queue between front and back
// Small FIFO of classified commands so that intake and execution stall
// independently.
// ----------------------------------------------------------------------------
module ght_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ght_pkg::cmd_t  push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ght_pkg::cmd_t  head_o
);

  ght_pkg::cmd_t                  entry_q [ght_pkg::QUEUE_DEPTH];
  logic [ght_pkg::Q_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ght_pkg::Q_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ght_pkg::Q_CNT_W-1:0]    count_q, count_d;

  assign full_o  = (count_q == ght_pkg::Q_CNT_W'(ght_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + ght_pkg::Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + ght_pkg::Q_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + ght_pkg::Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - ght_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ght_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_back: slot table and command sequencer
// Holds the slot table and walks it one slot per cycle for acquire and
// collect; resolve takes one memory read. Results land in an output
// register that the consumer may stall.
// ----------------------------------------------------------------------------
module ght_back #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEFAULT,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  ght_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [ght_pkg::OIDX_W-1:0]   slot_index_o,
  output logic [ght_pkg::OGEN_W-1:0]   generation_o,
  output logic [ght_pkg::KEY_W-1:0]    content_out_o,
  output logic [ght_pkg::EVICT_W-1:0]  evicted_count_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (GEN_BITS > ght_pkg::HGEN_W) ? GEN_BITS : ght_pkg::HGEN_W;

  typedef struct packed {
    logic [ght_pkg::ID_W-1:0]  id;
    logic [ght_pkg::KEY_W-1:0] key;
  } entry_t;

  ght_pkg::back_state_e  state_q, state_d;
  ght_pkg::cmd_t         cmd_q, cmd_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic [IDX_W-1:0]      pick_q, pick_d;
  logic                  pick_vld_q, pick_vld_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      siu_q, siu_d;
  logic [SLOTS-1:0]      occ_q, occ_d;
  logic [GEN_BITS-1:0]   gen_q [SLOTS];
  logic [GEN_BITS-1:0]   gen_d [SLOTS];
  logic                  out_vld_q, out_vld_d;
  ght_pkg::result_t      out_q, out_d;

  entry_t                mem [SLOTS];
  entry_t                rd_data_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;

  logic [SLOTS-1:0]      held_ext;

  // Held bits exist for the first slots only
  for (genvar g = 0; g < SLOTS; g++) begin : g_held
    if (g < ght_pkg::HELD_W) begin : g_in
      assign held_ext[g] = cmd_q.held[g];
    end else begin : g_out
      assign held_ext[g] = 1'b0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_q.status;
  assign slot_index_o    = out_q.slot_index;
  assign generation_o    = out_q.generation;
  assign content_out_o   = out_q.content;
  assign evicted_count_o = out_q.evicted;

  // Sequencer: next state, table updates and result
  always_comb begin
    logic             out_free;
    logic             last;
    logic             occ;
    logic             hit;
    logic             freed;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] ridx;
    logic [CNT_W-1:0] cnt_next;
    logic             res_ok;

    state_d    = state_q;
    cmd_d      = cmd_q;
    scan_d     = scan_q;
    pick_d     = pick_q;
    pick_vld_d = pick_vld_q;
    cnt_d      = cnt_q;
    siu_d      = siu_q;
    occ_d      = occ_q;
    gen_d      = gen_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    pop_o      = 1'b0;
    rd_addr    = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;

    out_free = !out_vld_q || !out_stall_i;
    last     = ((CNT_W'(scan_q) + CNT_W'(1)) == siu_q);
    occ      = occ_q[scan_q];
    hit      = occ && (rd_data_q.id == cmd_q.object_id);
    freed    = occ && !held_ext[scan_q];
    cnt_next = cnt_q + CNT_W'(freed);
    p        = pick_vld_q ? pick_q : IDX_W'(siu_q);
    ridx     = cmd_q.slot[IDX_W-1:0];
    res_ok   = (CNT_W'(ridx) < siu_q) &&
               (CMP_W'(gen_q[ridx]) == CMP_W'(cmd_q.gen)) && occ_q[ridx];

    unique case (state_q)
      ght_pkg::BK_IDLE: begin
        // Take the next command once the output register can receive it
        if (cmd_valid_i && out_free) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            ght_pkg::CMD_ACQUIRE: begin
              scan_d     = '0;
              pick_vld_d = 1'b0;
              state_d    = (siu_q == '0) ? ght_pkg::BK_PLACE : ght_pkg::BK_SCAN;
            end
            ght_pkg::CMD_RESOLVE: begin
              rd_addr = cmd_i.slot[IDX_W-1:0];
              state_d = ght_pkg::BK_RESOLVE;
            end
            ght_pkg::CMD_COLLECT: begin
              scan_d = '0;
              cnt_d  = '0;
              if (siu_q == '0) begin
                out_vld_d = 1'b1;
                out_d     = ght_pkg::mk_result(ght_pkg::STATUS_OK, '0, '0, '0, '0);
              end else begin
                state_d = ght_pkg::BK_COLLECT;
              end
            end
            ght_pkg::CMD_MISSING: begin
              out_vld_d = 1'b1;
              out_d     = ght_pkg::mk_result(ght_pkg::STATUS_MISSING, '0, '0, '0, '0);
            end
            ght_pkg::CMD_STALE: begin
              out_vld_d = 1'b1;
              out_d     = ght_pkg::mk_result(ght_pkg::STATUS_STALE, '0, '0, '0, '0);
            end
            default: begin
              out_vld_d = 1'b1;
              out_d     = ght_pkg::mk_result(ght_pkg::STATUS_OK, '0, '0, '0, '0);
            end
          endcase
        end
      end

      ght_pkg::BK_SCAN: begin
        // Compare one slot per cycle, remember the first reusable free slot
        if (hit) begin
          out_vld_d = 1'b1;
          state_d   = ght_pkg::BK_IDLE;
          if (rd_data_q.key == cmd_q.content_key) begin
            out_d = ght_pkg::mk_result(ght_pkg::STATUS_OK, ght_pkg::OIDX_W'(scan_q),
                                       ght_pkg::OGEN_W'(gen_q[scan_q]), '0, '0);
          end else begin
            out_d = ght_pkg::mk_result(ght_pkg::STATUS_COLLISION, '0, '0, '0, '0);
          end
        end else begin
          if (!occ && (gen_q[scan_q] != '0) && !pick_vld_q) begin
            pick_d     = scan_q;
            pick_vld_d = 1'b1;
          end
          if (last) begin
            state_d = ght_pkg::BK_PLACE;
          end else begin
            scan_d  = scan_q + IDX_W'(1);
            rd_addr = scan_q + IDX_W'(1);
          end
        end
      end

      ght_pkg::BK_PLACE: begin
        // Reuse the picked slot or append one; report full when neither is possible
        out_vld_d = 1'b1;
        state_d   = ght_pkg::BK_IDLE;
        if (!pick_vld_q && (siu_q == CNT_W'(SLOTS))) begin
          out_d = ght_pkg::mk_result(ght_pkg::STATUS_FULL, '0, '0, '0, '0);
        end else begin
          occ_d[p]  = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = p;
          if (!pick_vld_q) begin
            siu_d = siu_q + CNT_W'(1);
          end
          out_d = ght_pkg::mk_result(ght_pkg::STATUS_OK, ght_pkg::OIDX_W'(p),
                                     ght_pkg::OGEN_W'(gen_q[p]), '0, '0);
        end
      end

      ght_pkg::BK_RESOLVE: begin
        // Check the slot against the handle
        out_vld_d = 1'b1;
        state_d   = ght_pkg::BK_IDLE;
        if (res_ok) begin
          out_d = ght_pkg::mk_result(ght_pkg::STATUS_OK, ght_pkg::OIDX_W'(ridx),
                                     cmd_q.gen, rd_data_q.key, '0);
        end else begin
          out_d = ght_pkg::mk_result(ght_pkg::STATUS_STALE, '0, '0, '0, '0);
        end
      end

      ght_pkg::BK_COLLECT: begin
        // Free one unheld slot per cycle, retire it at the top generation
        if (freed) begin
          occ_d[scan_q] = 1'b0;
          gen_d[scan_q] = (&gen_q[scan_q]) ? '0 : gen_q[scan_q] + GEN_BITS'(1);
        end
        if (last) begin
          out_vld_d = 1'b1;
          state_d   = ght_pkg::BK_IDLE;
          out_d     = ght_pkg::mk_result(ght_pkg::STATUS_OK, '0, '0, '0,
                                         ght_pkg::EVICT_W'(cnt_next));
        end else begin
          scan_d = scan_q + IDX_W'(1);
          cnt_d  = cnt_next;
        end
      end

      default: begin
        state_d = ght_pkg::BK_IDLE;
      end
    endcase
  end

  // Control and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ght_pkg::BK_IDLE;
      pick_vld_q <= 1'b0;
      siu_q      <= '0;
      occ_q      <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        gen_q[i] <= GEN_BITS'(1);
      end
    end else begin
      state_q    <= state_d;
      pick_vld_q <= pick_vld_d;
      siu_q      <= siu_d;
      occ_q      <= occ_d;
      out_vld_q  <= out_vld_d;
      gen_q      <= gen_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    scan_q <= scan_d;
    pick_q <= pick_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  // Id and key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= '{id: cmd_q.object_id, key: cmd_q.content_key};
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/generational_handle_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_core: generational slot map with handles
// Acquires slots by object id, resolves handles against slot generations and
// collects unheld slots. A front stage classifies requests into a command
// queue; a back sequencer executes them against the slot table.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ---------------------------
//  in       input      in_valid_i / in_stall_o    opcode .. held_mask
//  out      output     out_valid_o / out_stall_i  status .. evicted_count
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_owner_id_i
//
//  A request first enters the queue. The back sequencer then walks the slots
//  in use one slot per cycle for acquire (stopping early on an id match) and
//  for collect (no walk on a never used table); resolve reads one memory
//  word, and other requests are answered straight from the idle state.
//  Reset clears all slots to free with generation 1; no clearing pass.
//  The front keeps accepting up to two requests while a result is stalled.
//
module generational_handle_table_core #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEFAULT,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic                         has_descriptor_i,
  input  logic [ght_pkg::ID_W-1:0]     object_id_i,
  input  logic [ght_pkg::KEY_W-1:0]    content_key_i,
  input  logic [ght_pkg::OWNER_W-1:0]  handle_owner_i,
  input  logic [ght_pkg::HSLOT_W-1:0]  handle_slot_i,
  input  logic [ght_pkg::HGEN_W-1:0]   handle_generation_i,
  input  logic [ght_pkg::HELD_W-1:0]   held_mask_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [ght_pkg::OIDX_W-1:0]   slot_index_o,
  output logic [ght_pkg::OGEN_W-1:0]   generation_o,
  output logic [ght_pkg::KEY_W-1:0]    content_out_o,
  output logic [ght_pkg::EVICT_W-1:0]  evicted_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ght_pkg::OWNER_W-1:0]  cfg_owner_id_i
);

  logic [ght_pkg::OWNER_W-1:0] owner_q;
  logic                        push;
  ght_pkg::cmd_t               push_cmd;
  logic                        queue_full;
  logic                        pop;
  logic                        cmd_valid;
  ght_pkg::cmd_t               head_cmd;

  // Owner register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else if (cfg_valid_i) begin
      owner_q <= cfg_owner_id_i;
    end
  end

  ght_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .has_descriptor_i    (has_descriptor_i),
    .object_id_i         (object_id_i),
    .content_key_i       (content_key_i),
    .handle_owner_i      (handle_owner_i),
    .handle_slot_i       (handle_slot_i),
    .handle_generation_i (handle_generation_i),
    .held_mask_i         (held_mask_i),
    .owner_id_i          (owner_q),
    .queue_full_i        (queue_full),
    .push_o              (push),
    .cmd_o               (push_cmd)
  );

  ght_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .head_o      (head_cmd)
  );

  ght_back #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .generation_o    (generation_o),
    .content_out_o   (content_out_o),
    .evicted_count_o (evicted_count_o)
  );

endmodule

// ===== hw/rtl/ght_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_checker: port-level checks of the handle table
// Watches the output channel for held transactions and for results whose
// fields disagree with their status.
// ----------------------------------------------------------------------------
module ght_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [2:0]                   status_o,
  input logic [ght_pkg::OIDX_W-1:0]   slot_index_o,
  input logic [ght_pkg::OGEN_W-1:0]   generation_o,
  input logic [ght_pkg::KEY_W-1:0]    content_out_o,
  input logic [ght_pkg::EVICT_W-1:0]  evicted_count_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_index_o) && $stable(generation_o) && $stable(content_out_o) &&
    $stable(evicted_count_o))
    else $error("stalled result changed");

  // Error results carry no handle
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ght_pkg::STATUS_OK) |->
    (slot_index_o == '0) && (generation_o == '0) && (content_out_o == '0) &&
    (evicted_count_o == '0))
    else $error("error result carries data");

  // A collect result names no slot
  a_collect_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (evicted_count_o != '0) |->
    (status_o == ght_pkg::STATUS_OK) && (slot_index_o == '0) &&
    (generation_o == '0) && (content_out_o == '0))
    else $error("collect result mixed with handle");

  // Content is returned only with a live generation
  a_content_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (content_out_o != '0) |-> (generation_o != '0))
    else $error("content returned without generation");

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (.*);

// ===== bench/tb_generational_handle_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_table_core: self-checking bench of the handle table
// Drives acquire, resolve and collect requests under random sender gaps and
// receiver stalls. A slot table kept in the bench predicts every result but
// the hand-written ones of the directed rows. Random traffic fills, resolves
// and collects the table under several owner settings.
// ----------------------------------------------------------------------------
module tb_generational_handle_table_core;

  localparam int          NSLOTS     = ght_pkg::SLOTS_DEFAULT;
  localparam int          ID_POOL    = 24;
  localparam int          HANDLE_CAP = 32;
  localparam int          SCRIPT_LEN = 23;
  localparam logic [31:0] ALL1       = 32'hFFFF_FFFF;

  typedef struct packed {
    ght_pkg::op_e                 op;
    logic                         desc;
    logic [ght_pkg::ID_W-1:0]     id;
    logic [ght_pkg::KEY_W-1:0]    key;
    logic [ght_pkg::OWNER_W-1:0]  owner;
    logic [ght_pkg::HSLOT_W-1:0]  slot;
    logic [ght_pkg::HGEN_W-1:0]   gen;
    logic [ght_pkg::HELD_W-1:0]   held;
  } request_t;

  // Directed row: request plus a hand-written result where typed is set
  typedef struct packed {
    request_t          rq;
    logic              typed;
    ght_pkg::result_t  want;
  } script_row_t;

  typedef struct packed {
    logic [3:0]   slot;
    logic [15:0]  gen;
  } handle_t;

  logic                          clk_i;
  logic                          rst_ni              = 1'b0;
  logic                          in_valid_i          = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    opcode_i            = '0;
  logic                          has_descriptor_i    = 1'b0;
  logic [ght_pkg::ID_W-1:0]      object_id_i         = '0;
  logic [ght_pkg::KEY_W-1:0]     content_key_i       = '0;
  logic [ght_pkg::OWNER_W-1:0]   handle_owner_i      = '0;
  logic [ght_pkg::HSLOT_W-1:0]   handle_slot_i       = '0;
  logic [ght_pkg::HGEN_W-1:0]    handle_generation_i = '0;
  logic [ght_pkg::HELD_W-1:0]    held_mask_i         = '0;
  logic                          out_valid_o;
  logic                          out_stall_i         = 1'b0;
  logic [2:0]                    status_o;
  logic [ght_pkg::OIDX_W-1:0]    slot_index_o;
  logic [ght_pkg::OGEN_W-1:0]    generation_o;
  logic [ght_pkg::KEY_W-1:0]     content_out_o;
  logic [ght_pkg::EVICT_W-1:0]   evicted_count_o;
  logic                          cfg_valid_i         = 1'b0;
  logic                          cfg_ready_o;
  logic [ght_pkg::OWNER_W-1:0]   cfg_owner_id_i      = '0;

  // Shadow copy of the slot table and the owner register
  logic                 slot_busy [NSLOTS];
  logic [15:0]          slot_gen  [NSLOTS];
  logic [31:0]          slot_id   [NSLOTS];
  logic [31:0]          slot_key  [NSLOTS];
  int                   high_water;
  logic [7:0]           owner_reg;

  ght_pkg::result_t     pending_results [$];
  handle_t              live_handles [$];
  logic [31:0]          id_pool  [ID_POOL];
  logic [31:0]          key_pool [ID_POOL];
  script_row_t          dir_script [SCRIPT_LEN];
  ght_pkg::result_t     got_want;
  int                   fail_count;
  int                   send_gap_pct;
  int                   recv_stall_pct;

  generational_handle_table_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .has_descriptor_i    (has_descriptor_i),
    .object_id_i         (object_id_i),
    .content_key_i       (content_key_i),
    .handle_owner_i      (handle_owner_i),
    .handle_slot_i       (handle_slot_i),
    .handle_generation_i (handle_generation_i),
    .held_mask_i         (held_mask_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .slot_index_o        (slot_index_o),
    .generation_o        (generation_o),
    .content_out_o       (content_out_o),
    .evicted_count_o     (evicted_count_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_owner_id_i      (cfg_owner_id_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Work out the result of one request and advance the shadow table
  function automatic ght_pkg::result_t apply_request(request_t rq);
    ght_pkg::result_t r;
    int      i;
    int      pick;
    bit      found;
    r        = '0;
    r.status = ght_pkg::STATUS_OK;
    case (rq.op)
      ght_pkg::OP_ACQUIRE: begin
        if (!rq.desc) begin
          r.status = ght_pkg::STATUS_MISSING;
        end else begin
          found = 1'b0;
          for (i = 0; i < high_water; i++) begin
            if (!found && slot_busy[i] && slot_id[i] == rq.id) begin
              found = 1'b1;
              if (slot_key[i] != rq.key) begin
                r.status = ght_pkg::STATUS_COLLISION;
              end else begin
                r.slot_index = i[3:0];
                r.generation = slot_gen[i];
              end
            end
          end
          if (!found) begin
            // Reuse the first free, unretired slot, else append one
            pick = -1;
            for (i = 0; i < high_water; i++) begin
              if (pick < 0 && !slot_busy[i] && slot_gen[i] != 16'd0) pick = i;
            end
            if (pick < 0 && high_water >= NSLOTS) begin
              r.status = ght_pkg::STATUS_FULL;
            end else begin
              if (pick < 0) begin
                pick = high_water;
                high_water++;
              end
              slot_busy[pick] = 1'b1;
              slot_id[pick]   = rq.id;
              slot_key[pick]  = rq.key;
              r.slot_index    = pick[3:0];
              r.generation    = slot_gen[pick];
            end
          end
          if (r.status == ght_pkg::STATUS_OK) begin
            live_handles.push_back('{r.slot_index, r.generation});
            if (live_handles.size() > HANDLE_CAP) void'(live_handles.pop_front());
          end
        end
      end
      ght_pkg::OP_RESOLVE: begin
        if (rq.owner != owner_reg || rq.gen == 16'd0 || rq.slot >= high_water) begin
          r.status = ght_pkg::STATUS_STALE;
        end else if (slot_gen[rq.slot[3:0]] != rq.gen || !slot_busy[rq.slot[3:0]]) begin
          r.status = ght_pkg::STATUS_STALE;
        end else begin
          r.slot_index = rq.slot[3:0];
          r.generation = rq.gen;
          r.content    = slot_key[rq.slot[3:0]];
        end
      end
      ght_pkg::OP_COLLECT: begin
        // Free unheld slots; a slot at the top generation retires at zero
        for (i = 0; i < high_water; i++) begin
          if (slot_busy[i] && !rq.held[i]) begin
            slot_busy[i] = 1'b0;
            slot_gen[i]  = (slot_gen[i] == 16'hFFFF) ? 16'd0 : slot_gen[i] + 16'd1;
            r.evicted    = r.evicted + 5'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly well-formed requests over a small id pool, the rest pure noise
  function automatic request_t draw_request();
    request_t rq;
    handle_t  h;
    int       pick;
    int       k;
    rq.op    = ght_pkg::op_e'($urandom_range(3));
    rq.desc  = 1'($urandom);
    rq.id    = $urandom;
    rq.key   = $urandom;
    rq.owner = 8'($urandom);
    rq.slot  = 8'($urandom);
    rq.gen   = 16'($urandom);
    rq.held  = 16'($urandom);
    pick     = $urandom_range(99);
    if (pick >= 15 && pick < 65) begin
      rq.op   = ght_pkg::OP_ACQUIRE;
      rq.desc = ($urandom_range(99) >= 3);
      k       = $urandom_range(ID_POOL - 1);
      rq.id   = id_pool[k];
      if ($urandom_range(9) != 0) rq.key = key_pool[k];
    end else if (pick >= 65 && pick < 96) begin
      rq.op = ght_pkg::OP_RESOLVE;
      if ($urandom_range(9) != 0) rq.owner = owner_reg;
      if (live_handles.size() > 0) begin
        h       = live_handles[$urandom_range(live_handles.size() - 1)];
        rq.slot = {4'd0, h.slot};
        rq.gen  = ($urandom_range(9) == 0) ? h.gen + 16'd1 : h.gen;
      end else begin
        rq.slot = 8'($urandom_range(NSLOTS - 1));
        rq.gen  = 16'($urandom_range(1, 3));
      end
    end else if (pick >= 96) begin
      // Hold most slots so the table gets a chance to fill up
      rq.op = ght_pkg::OP_COLLECT;
      k     = $urandom_range(3);
      if (k == 0) rq.held = 16'h0000;
      else if (k == 1) rq.held = 16'hFFFF;
      else rq.held = 16'($urandom | $urandom);
    end
    return rq;
  endfunction

  // Present one transaction, hold it until accepted, then log its expectation
  task automatic send_request(input request_t rq, input logic typed,
                              input ght_pkg::result_t want);
    ght_pkg::result_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    opcode_i            <= rq.op;
    has_descriptor_i    <= rq.desc;
    object_id_i         <= rq.id;
    content_key_i       <= rq.key;
    handle_owner_i      <= rq.owner;
    handle_slot_i       <= rq.slot;
    handle_generation_i <= rq.gen;
    held_mask_i         <= rq.held;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_request(rq);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_owner(input logic [7:0] value);
    cfg_valid_i    <= 1'b1;
    cfg_owner_id_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    owner_reg   = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  // Receiver: random stall per cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: expected none, got status %0d",
                 $time, status_o);
      end else begin
        got_want = pending_results.pop_front();
        check_field("status", 32'(got_want.status), 32'(status_o));
        check_field("slot_index", 32'(got_want.slot_index), 32'(slot_index_o));
        check_field("generation", 32'(got_want.generation), 32'(generation_o));
        check_field("content_out", got_want.content, content_out_o);
        check_field("evicted_count", 32'(got_want.evicted), 32'(evicted_count_o));
      end
    end
  end

  initial begin
    request_t rq;
    int       n;
    fail_count     = 0;
    send_gap_pct   = 16;
    recv_stall_pct = 46;
    owner_reg      = 8'd0;
    high_water     = 0;
    for (n = 0; n < NSLOTS; n++) begin
      slot_busy[n] = 1'b0;
      slot_gen[n]  = 16'd1;
      slot_id[n]   = '0;
      slot_key[n]  = '0;
    end
    for (n = 0; n < ID_POOL; n++) begin
      id_pool[n]  = $urandom;
      key_pool[n] = $urandom;
    end

    // Owner stays at its reset value of zero for the directed rows
    dir_script = '{
      // resolve on an empty table
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 16'd1, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      // acquire without descriptor
      '{'{ght_pkg::OP_ACQUIRE, 1'b0, 32'd7, 32'd7, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_MISSING, 4'd0, 16'd0, 32'd0, 5'd0}},
      // unused opcode with every field at its top
      '{'{ght_pkg::OP_NOP, 1'b1, ALL1, ALL1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{ght_pkg::STATUS_OK, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_COLLECT, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_OK, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_OK, 4'd0, 16'd1, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, ALL1, ALL1, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_OK, 4'd1, 16'd1, 32'd0, 5'd0}},
      // same id, other content
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, 32'd0, 32'd1, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_COLLISION, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_OK, 4'd0, 16'd1, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd1, 16'd1, 16'd0},
        1'b1, '{ght_pkg::STATUS_OK, 4'd1, 16'd1, ALL1, 5'd0}},
      // wrong owner, zero generation, slot out of range, slot at high water
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'hFF, 8'd1, 16'd1, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd1, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'hFF, 16'hFFFF, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd2, 16'd1, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      // generation mismatch
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd1, 16'd2, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      // everything held, then only slot zero held
      '{'{ght_pkg::OP_COLLECT, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'hFFFF},
        1'b1, '{ght_pkg::STATUS_OK, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_COLLECT, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'h0001},
        1'b1, '{ght_pkg::STATUS_OK, 4'd0, 16'd0, 32'd0, 5'd1}},
      // old generation, then a free slot with the current generation
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd1, 16'd1, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd1, 16'd2, 16'd0},
        1'b1, '{ght_pkg::STATUS_STALE, 4'd0, 16'd0, 32'd0, 5'd0}},
      // reuse of the freed slot
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, ALL1, 32'd0, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b1, '{ght_pkg::STATUS_OK, 4'd1, 16'd2, 32'd0, 5'd0}},
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, 32'd3, 32'd9, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b0, '0},
      '{'{ght_pkg::OP_RESOLVE, 1'b0, 32'd0, 32'd0, 8'd0, 8'd2, 16'd1, 16'd0},
        1'b0, '0},
      '{'{ght_pkg::OP_COLLECT, 1'b0, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'hFFFE},
        1'b0, '0},
      '{'{ght_pkg::OP_ACQUIRE, 1'b1, 32'd0, 32'd5, 8'd0, 8'd0, 16'd0, 16'd0},
        1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < SCRIPT_LEN; n++)
      send_request(dir_script[n].rq, dir_script[n].typed, dir_script[n].want);

    // Free everything before the random traffic
    rq    = '0;
    rq.op = ght_pkg::OP_COLLECT;
    send_request(rq, 1'b0, '0);

    drain_results();
    live_handles.delete();
    set_owner(8'hFF);
    repeat (170) send_request(draw_request(), 1'b0, '0);

    drain_results();
    send_gap_pct   = 46;
    recv_stall_pct = 16;
    set_owner(8'h00);
    repeat (170) send_request(draw_request(), 1'b0, '0);

    drain_results();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_owner(8'($urandom_range(1, 254)));
    repeat (160) send_request(draw_request(), 1'b0, '0);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
